>>> rtl/key_edge_and_auto_repeat_unit_assert.svh
// Assertion macros for the key edge and auto-repeat unit.
`ifndef KEY_EDGE_AND_AUTO_REPEAT_UNIT_ASSERT_SVH
`define KEY_EDGE_AND_AUTO_REPEAT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KEAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define KEAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kear_pkg.sv
// Shared constants and beat types of the key edge and auto-repeat unit.
package kear_pkg;

  localparam int KEY_COUNT  = 256;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 8;
  localparam int HOLD_W     = 16;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = $clog2(KEY_COUNT);
  localparam int REM_W      = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

  localparam logic [CFG_W-1:0] RESET_DELAY    = 16'd30;
  localparam logic [CFG_W-1:0] RESET_INTERVAL = 16'd5;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             key_down;
  } sample_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic              pressed;
    logic              press_edge;
    logic              release_edge;
    logic              repeat_pulse;
    logic [HOLD_W-1:0] hold_frames;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] delay;
    logic [CFG_W-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic                  now;
    logic                  press;
    logic                  release_e;
    logic [COUNT_BITS-1:0] cnt;
  } upd_t;

endpackage

>>> rtl/key_edge_and_auto_repeat_unit.sv
// Key edge and auto-repeat unit: top level with configuration registers.
//
// sample channel: one beat per key sample (key index, level). A frame is one
// sweep over all keys; each beat gives exactly one result beat on the result
// channel, in order: level, press and release edges, saturating hold count
// and the typematic repeat pulse.
// Throughput: one beat per cycle while sample_stall is low, any mix of keys,
// the same key back to back included; the per-key read-modify-write closes
// in one stage with bypass. Path: the store read, update and delay compare
// stages, the 16 one-bit stages of the repeat-interval remainder pipeline
// and the output stage.
// Stall: the result register has one skid entry, so the pipeline moves on
// while a result waits; sample_stall rises only with that entry full and
// drops the cycle after the result is taken.
// Reset: the per-key store reads as zero (valid bits cleared at once), no
// clearing pass; repeat_delay returns to 30 and repeat_interval to 5.
// cfg_write writes register cfg_index (0 delay, 1 interval);
// write only with the pipeline empty.
module key_edge_and_auto_repeat_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  kear_pkg::sample_t              sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output kear_pkg::result_t              result,
  input  logic                           cfg_write,
  input  logic [kear_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kear_pkg::CFG_W-1:0]     cfg_data
);

  `include "key_edge_and_auto_repeat_unit_assert.svh"

  kear_pkg::cfg_t    cfg;
  logic              en;
  logic              upd_valid;
  kear_pkg::upd_t    upd;
  logic              res_valid;
  kear_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay    <= kear_pkg::RESET_DELAY;
      cfg.interval <= kear_pkg::RESET_INTERVAL;
    end else if (cfg_write) begin
      case (cfg_index)
        kear_pkg::REG_DELAY: begin
          cfg.delay <= cfg_data;
        end
        kear_pkg::REG_INTERVAL: begin
          cfg.interval <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign sample_stall = !en;

  kear_state u_state (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .sample_valid (sample_valid),
    .sample       (sample),
    .upd_valid    (upd_valid),
    .upd          (upd)
  );

  kear_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .upd_valid (upd_valid),
    .upd       (upd),
    .res_valid (res_valid),
    .res       (res)
  );

  kear_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .pipe_valid   (res_valid),
    .pipe_data    (res),
    .pipe_ready   (en),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  `KEAR_ASSERT_NOW(a_stall_needs_result, sample_stall, result_valid, "stall without held result")
  `KEAR_ASSERT_NEXT(a_skid_drains, !result_valid || !result_stall, !sample_stall, "skid not drained")
  `KEAR_ASSERT_NOW(a_press_first, result_valid && result.press_edge, result.pressed && (result.hold_frames == 16'd1) && result.repeat_pulse, "press edge without first hold frame")
  `KEAR_ASSERT_NOW(a_up_is_clear, result_valid && !result.pressed, (result.hold_frames == 16'd0) && !result.repeat_pulse && !result.press_edge, "released key with count or pulse")

endmodule

>>> rtl/kear_state.sv
// Per-key level and hold count store with read-modify-write update stages.
module kear_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              sample_valid,
  input  kear_pkg::sample_t sample,
  output logic              upd_valid,
  output kear_pkg::upd_t    upd
);

  typedef struct packed {
    logic                            level;
    logic [kear_pkg::COUNT_BITS-1:0] cnt;
  } entry_t;

  localparam logic [kear_pkg::COUNT_BITS-1:0] CNT_MAX = {kear_pkg::COUNT_BITS{1'b1}};

  entry_t                         mem [kear_pkg::KEY_COUNT];
  logic [kear_pkg::KEY_COUNT-1:0] filled;

  logic [kear_pkg::IDX_W-1:0] in_addr;
  logic                       in_ok;

  logic                       s1_valid;
  logic [kear_pkg::KEY_W-1:0] s1_key;
  logic [kear_pkg::IDX_W-1:0] s1_addr;
  logic                       s1_down;
  logic                       s1_ok;
  entry_t                     rd;
  logic                       rd_ok;
  logic                       byp;
  entry_t                     byp_entry;

  entry_t         cur;
  entry_t         nxt;
  logic           wr;
  kear_pkg::upd_t upd_next;

  assign in_addr = kear_pkg::IDX_W'({{kear_pkg::IDX_W{1'b0}}, sample.key_index});
  assign in_ok   = 32'(sample.key_index) < kear_pkg::KEY_COUNT;

  always_comb begin
    if (byp) begin
      cur = byp_entry;
    end else if (rd_ok) begin
      cur = rd;
    end else begin
      cur = '0;
    end
    nxt.level = s1_down;
    if (!s1_down) begin
      nxt.cnt = '0;
    end else if (cur.cnt == CNT_MAX) begin
      nxt.cnt = cur.cnt;
    end else begin
      nxt.cnt = cur.cnt + kear_pkg::COUNT_BITS'(1);
    end
    upd_next.key       = s1_key;
    upd_next.now       = s1_ok & s1_down;
    upd_next.press     = s1_ok & ~cur.level & s1_down;
    upd_next.release_e = s1_ok & cur.level & ~s1_down;
    upd_next.cnt       = s1_ok ? nxt.cnt : '0;
  end

  assign wr = en && s1_valid && s1_ok;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[s1_addr] <= nxt;
    end
    if (en) begin
      rd <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      s1_valid  <= 1'b0;
      upd_valid <= 1'b0;
    end else begin
      if (wr) begin
        filled[s1_addr] <= 1'b1;
      end
      if (en) begin
        s1_valid  <= sample_valid;
        upd_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_key    <= sample.key_index;
      s1_addr   <= in_addr;
      s1_down   <= sample.key_down;
      s1_ok     <= in_ok;
      rd_ok     <= filled[in_addr];
      byp       <= wr && (s1_addr == in_addr);
      byp_entry <= nxt;
      upd       <= upd_next;
    end
  end

endmodule

>>> rtl/kear_rem.sv
// Repeat decision: delay compare and a bit-per-stage remainder pipeline.
module kear_rem (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  kear_pkg::cfg_t    cfg,
  input  logic              upd_valid,
  input  kear_pkg::upd_t    upd,
  output logic              res_valid,
  output kear_pkg::result_t res
);

  localparam int RW = kear_pkg::REM_W;
  localparam int CW = kear_pkg::CFG_W;

  typedef struct packed {
    logic [kear_pkg::KEY_W-1:0]  key;
    logic                        pressed;
    logic                        press;
    logic                        release_e;
    logic                        nz;
    logic                        one;
    logic                        ge;
    logic [kear_pkg::HOLD_W-1:0] hold;
    logic [RW-1:0]               dvd;
    logic [CW-1:0]               rem;
  } stage_t;

  function automatic stage_t rem_step(stage_t s, logic [CW-1:0] ivl);
    stage_t      r;
    logic [CW:0] shifted;
    r       = s;
    shifted = {s.rem, s.dvd[RW-1]};
    if (shifted >= {1'b0, ivl}) begin
      r.rem = CW'(shifted - {1'b0, ivl});
    end else begin
      r.rem = shifted[CW-1:0];
    end
    r.dvd = s.dvd << 1;
    return r;
  endfunction

  stage_t        pipe [RW+1];
  stage_t        stepped [RW];
  logic [RW:0]   pv;
  stage_t        s0;
  logic [CW-1:0] ivl;
  logic [RW-1:0] cnt_w;
  logic [RW-1:0] dly_w;
  stage_t        last;

  assign ivl   = (cfg.interval == '0) ? CW'(1) : cfg.interval;
  assign cnt_w = RW'(upd.cnt);
  assign dly_w = RW'(cfg.delay);

  always_comb begin
    s0.key       = upd.key;
    s0.pressed   = upd.now;
    s0.press     = upd.press;
    s0.release_e = upd.release_e;
    s0.nz        = cnt_w != '0;
    s0.one       = cnt_w == RW'(1);
    s0.ge        = cnt_w >= dly_w;
    if (cnt_w > RW'({kear_pkg::HOLD_W{1'b1}})) begin
      s0.hold = {kear_pkg::HOLD_W{1'b1}};
    end else begin
      s0.hold = cnt_w[kear_pkg::HOLD_W-1:0];
    end
    s0.dvd = cnt_w - dly_w;
    s0.rem = '0;
  end

  always_comb begin
    for (int j = 0; j < RW; j++) begin
      stepped[j] = rem_step(pipe[j], ivl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[RW-1:0], upd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= s0;
      for (int j = 0; j < RW; j++) begin
        pipe[j+1] <= stepped[j];
      end
    end
  end

  assign last      = pipe[RW];
  assign res_valid = pv[RW];

  always_comb begin
    res.key_id       = last.key;
    res.pressed      = last.pressed;
    res.press_edge   = last.press;
    res.release_edge = last.release_e;
    res.repeat_pulse = last.nz && (last.one || (last.ge && (last.rem == '0)));
    res.hold_frames  = last.hold;
  end

endmodule

>>> rtl/kear_skid.sv
// Output register with one skid entry that frees the pipeline from the stall.
module kear_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              pipe_valid,
  input  kear_pkg::result_t pipe_data,
  output logic              pipe_ready,
  output logic              result_valid,
  output kear_pkg::result_t result,
  input  logic              result_stall
);

  logic              held_valid;
  kear_pkg::result_t held;

  assign pipe_ready = !held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      held_valid   <= 1'b0;
    end else begin
      if (!result_valid || !result_stall) begin
        if (held_valid) begin
          result       <= held;
          result_valid <= 1'b1;
          held_valid   <= 1'b0;
        end else begin
          result       <= pipe_data;
          result_valid <= pipe_valid;
        end
      end else if (!held_valid && pipe_valid) begin
        held       <= pipe_data;
        held_valid <= 1'b1;
      end
    end
  end

endmodule

>>> verif/key_edge_and_auto_repeat_checker.sv
// Checker for the key edge and auto-repeat unit: tracks per-key state and compares result beats.
module key_edge_and_auto_repeat_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  input  logic                           sample_stall,
  input  kear_pkg::sample_t              sample,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  kear_pkg::result_t              result,
  input  logic                           cfg_write,
  input  logic [kear_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kear_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                            level_mem [kear_pkg::KEY_COUNT];
  logic [kear_pkg::COUNT_BITS-1:0] held_mem [kear_pkg::KEY_COUNT];
  logic [kear_pkg::CFG_W-1:0]      delay_r;
  logic [kear_pkg::CFG_W-1:0]      interval_r;
  kear_pkg::result_t               key_result_q[$];
  kear_pkg::result_t               want;
  int                              errors = 0;

  assign fail_count = errors;

  function automatic logic repeat_due(input logic [kear_pkg::COUNT_BITS-1:0] cnt);
    logic [kear_pkg::CFG_W-1:0] step;
    step = (interval_r == '0) ? kear_pkg::CFG_W'(1) : interval_r;
    if (cnt == '0) return 1'b0;
    if (cnt == kear_pkg::COUNT_BITS'(1)) return 1'b1;
    if (cnt >= delay_r) return ((cnt - delay_r) % step) == '0;
    return 1'b0;
  endfunction

  function automatic kear_pkg::result_t track_key(input kear_pkg::sample_t s);
    kear_pkg::result_t               r;
    logic                            prev;
    logic [kear_pkg::COUNT_BITS-1:0] cnt;
    r = '0;
    r.key_id = s.key_index;
    prev = level_mem[s.key_index];
    cnt = held_mem[s.key_index];
    if (s.key_down) begin
      if (cnt != '1) cnt = cnt + 1'b1;
    end else begin
      cnt = '0;
    end
    held_mem[s.key_index] = cnt;
    level_mem[s.key_index] = s.key_down;
    r.pressed = s.key_down;
    r.press_edge = !prev && s.key_down;
    r.release_edge = prev && !s.key_down;
    r.repeat_pulse = repeat_due(cnt);
    r.hold_frames = kear_pkg::HOLD_W'(cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [kear_pkg::HOLD_W-1:0] exp_v,
                             input logic [kear_pkg::HOLD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < kear_pkg::KEY_COUNT; k++) begin
        level_mem[k] = 1'b0;
        held_mem[k] = '0;
      end
      delay_r = kear_pkg::RESET_DELAY;
      interval_r = kear_pkg::RESET_INTERVAL;
      key_result_q.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          kear_pkg::REG_DELAY: begin
            delay_r = cfg_data;
          end
          kear_pkg::REG_INTERVAL: begin
            interval_r = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (sample_valid && !sample_stall) key_result_q.push_back(track_key(sample));
      if (result_valid && !result_stall) begin
        if (key_result_q.size() == 0) begin
          $display("%0t ns: result beat with none expected, expected nothing, actual key %0d",
                   $time, result.key_id);
          errors++;
        end else begin
          want = key_result_q.pop_front();
          check_field("key_id", kear_pkg::HOLD_W'(want.key_id),
                      kear_pkg::HOLD_W'(result.key_id));
          check_field("pressed", kear_pkg::HOLD_W'(want.pressed),
                      kear_pkg::HOLD_W'(result.pressed));
          check_field("press_edge", kear_pkg::HOLD_W'(want.press_edge),
                      kear_pkg::HOLD_W'(result.press_edge));
          check_field("release_edge", kear_pkg::HOLD_W'(want.release_edge),
                      kear_pkg::HOLD_W'(result.release_edge));
          check_field("repeat_pulse", kear_pkg::HOLD_W'(want.repeat_pulse),
                      kear_pkg::HOLD_W'(result.repeat_pulse));
          check_field("hold_frames", want.hold_frames, result.hold_frames);
        end
      end
      pending <= key_result_q.size();
    end
  end

endmodule

>>> verif/tb_key_edge_and_auto_repeat_unit.sv
// Testbench top for the key edge and auto-repeat unit: stimulus, idling and verdict.
module tb_key_edge_and_auto_repeat_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  kear_pkg::sample_t              sample = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  kear_pkg::result_t              result;
  logic                           cfg_write = 1'b0;
  logic [kear_pkg::CFG_IDX_W-1:0] cfg_index = kear_pkg::REG_DELAY;
  logic [kear_pkg::CFG_W-1:0]     cfg_data = '0;
  int                             fail_count;
  int                             pending;
  logic                           idle_en = 1'b1;
  int unsigned                    samples_sent = 0;
  int unsigned                    settings_used = 1;

  key_edge_and_auto_repeat_unit dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  key_edge_and_auto_repeat_checker checker_i (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    result_stall <= idle_en && !rst && ($urandom_range(99) < 13);
  end

  task automatic send_sample(input logic [kear_pkg::KEY_W-1:0] key, input logic down);
    if (idle_en && $urandom_range(99) < 15) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{key_index: key, key_down: down};
    do @(posedge clk); while (sample_stall);
    samples_sent++;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_config(input logic [kear_pkg::CFG_W-1:0] delay_v,
                            input logic [kear_pkg::CFG_W-1:0] ivl_v);
    drain();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= kear_pkg::REG_DELAY;
    cfg_data <= delay_v;
    @(posedge clk);
    cfg_index <= kear_pkg::REG_INTERVAL;
    cfg_data <= ivl_v;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic scan_frames(input int unsigned n);
    logic [kear_pkg::KEY_W-1:0] keys [6];
    logic                       lvl [6];
    int unsigned                done;
    done = 0;
    foreach (keys[k]) begin
      keys[k] = kear_pkg::KEY_W'($urandom_range(255));
      lvl[k] = 1'($urandom_range(1));
    end
    while (done < n) begin
      foreach (keys[k]) begin
        if ($urandom_range(99) < 12) lvl[k] = ~lvl[k];
        send_sample(keys[k], lvl[k]);
        done++;
        if ($urandom_range(99) < 8) begin
          send_sample(kear_pkg::KEY_W'($urandom), 1'($urandom));
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: edges on the lowest and highest keys
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b1);
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd128, 1'b1);

    set_config(16'd3, 16'd2);
    repeat (6) send_sample(8'd9, 1'b1);
    send_sample(8'd9, 1'b0);

    // zero delay and zero interval
    set_config(16'd0, 16'd0);
    repeat (3) send_sample(8'd200, 1'b1);
    send_sample(8'd200, 1'b0);
    send_sample(8'd200, 1'b0);

    set_config(16'd1, 16'hFFFF);
    repeat (3) send_sample(8'd1, 1'b1);
    send_sample(8'd1, 1'b0);

    // hold one key through many repeat intervals, no idling on either side
    set_config(16'd40, 16'd7);
    idle_en <= 1'b0;
    repeat (100) send_sample(8'd7, 1'b1);
    send_sample(8'd7, 1'b0);
    drain();
    idle_en <= 1'b1;

    set_config(16'd2, 16'd1);
    scan_frames(80);
    set_config(16'd5, 16'd3);
    scan_frames(80);
    set_config(16'd0, 16'd0);
    scan_frames(80);
    set_config(16'hFFFF, 16'd1);
    scan_frames(50);
    set_config(kear_pkg::CFG_W'($urandom_range(1, 12)), kear_pkg::CFG_W'($urandom_range(1, 6)));
    scan_frames(120);

    drain();
    repeat (25) @(posedge clk);
    $display("covered %0d key samples over %0d register settings,", samples_sent, settings_used);
    $display("including zero and full-scale delay and interval and a long hold with no idling");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/kear_pkg.sv
rtl/kear_state.sv
rtl/kear_rem.sv
rtl/kear_skid.sv
rtl/key_edge_and_auto_repeat_unit.sv
verif/key_edge_and_auto_repeat_checker.sv
verif/tb_key_edge_and_auto_repeat_unit.sv
